@@ hw/rtl/gfrc_pkg.sv @@
`timescale 1ns / 1ps

package gfrc_pkg;

	localparam int ENTRIES    = 28;
	localparam int AGE_BITS   = 16;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int HOST_FIRST = 4;
	localparam int OFF_W      = 16;
	localparam int REG_W      = 5;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] MODE_ACCESS  = 2'd0;
	localparam logic [1:0] MODE_FLUSH   = 2'd1;
	localparam logic [1:0] MODE_DISCARD = 2'd2;

	localparam logic [1:0] KIND_REPLY = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_STORE = 2'd2;

	typedef enum logic [1:0] {
		OP_ACCESS,
		OP_FLUSH,
		OP_DISCARD,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [REG_W-1:0] guest_reg;
		logic             upper_half;
		logic             preload;
	} in_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic [REG_W-1:0]        host_reg;
		logic signed [OFF_W-1:0] mem_offset;
		logic                    last;
	} out_t;

	// classified beat handed from front to back
	typedef struct packed {
		op_t              op;
		logic [REG_W-1:0] guest;
		logic             half;
		logic             pre;
		logic [OFF_W-1:0] load_off;
	} cmd_t;

	// base + reg*16 + half*8, wrapped
	function automatic logic [OFF_W-1:0] slot_offset(input logic [OFF_W-1:0] base,
			input logic [REG_W-1:0] reg_num, input logic half);
		return base + OFF_W'({reg_num, 4'b0000}) + OFF_W'({half, 3'b000});
	endfunction

	function automatic logic [REG_W-1:0] host_of(input logic [IDX_W-1:0] idx);
		return REG_W'(HOST_FIRST + int'(idx));
	endfunction

endpackage

@@ hw/rtl/gfrc_front.sv @@
`timescale 1ns / 1ps

module gfrc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  gfrc_pkg::in_t             in_data,
	input  logic [gfrc_pkg::OFF_W-1:0] base,
	output logic                      push_valid,
	input  logic                      push_ready,
	output gfrc_pkg::cmd_t            push_data
);
	import gfrc_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t decoded;
	logic load_en;

	always_comb begin
		decoded.guest    = in_data.guest_reg;
		decoded.half     = in_data.upper_half;
		decoded.pre      = in_data.preload;
		decoded.load_off = slot_offset(base, in_data.guest_reg, in_data.upper_half);
		unique case (in_data.mode)
			MODE_ACCESS:  decoded.op = OP_ACCESS;
			MODE_FLUSH:   decoded.op = OP_FLUSH;
			MODE_DISCARD: decoded.op = OP_DISCARD;
			default:      decoded.op = OP_NOP;
		endcase
	end

	assign load_en    = !valid_s1 || push_ready;
	assign in_stall   = !load_en;
	assign push_valid = valid_s1;
	assign push_data  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en && in_valid) begin
			cmd_s1 <= decoded;
		end
	end

endmodule

@@ hw/rtl/gfrc_queue.sv @@
`timescale 1ns / 1ps

module gfrc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  gfrc_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output gfrc_pkg::cmd_t pop_data
);
	import gfrc_pkg::*;

	cmd_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;
	logic                   push;
	logic                   pop;

	assign push_ready = count_q != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_PTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_PTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ hw/rtl/gfrc_back.sv @@
`timescale 1ns / 1ps

module gfrc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [gfrc_pkg::OFF_W-1:0] base,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  gfrc_pkg::cmd_t             q_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output gfrc_pkg::out_t             out_data
);
	import gfrc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_STORE,
		ST_LOAD,
		ST_REPLY,
		ST_DONE,
		ST_FLUSH
	} state_t;

	localparam logic [AGE_BITS-1:0] AGE_MAX  = '1;
	localparam logic [IDX_W-1:0]    IDX_LAST = IDX_W'(ENTRIES - 1);

	state_t               state_q;
	cmd_t                 cmd_q;
	logic [IDX_W-1:0]     sel_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [AGE_BITS-1:0]  best_age_q;
	logic                 out_valid_q;
	out_t                 out_q;

	logic                 valid_q [ENTRIES];
	logic                 away_q  [ENTRIES];
	logic [AGE_BITS-1:0]  age_q   [ENTRIES];
	logic [REG_W-1:0]     guest_q [ENTRIES];
	logic                 half_q  [ENTRIES];

	logic                 hit_found;
	logic [IDX_W-1:0]     hit_idx;
	logic                 empty_found;
	logic [IDX_W-1:0]     empty_idx;
	logic                 out_free;
	logic [IDX_W-1:0]     rd_idx;
	logic [OFF_W-1:0]     store_off;
	logic [AGE_BITS-1:0]  scan_age;
	logic                 scan_take;
	logic [IDX_W-1:0]     scan_idx;

	// parallel tag compare and free-slot search, lowest index wins
	always_comb begin
		hit_found   = 1'b0;
		hit_idx     = '0;
		empty_found = 1'b0;
		empty_idx   = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && guest_q[i] == q_data.guest && half_q[i] == q_data.half) begin
				hit_found = 1'b1;
				hit_idx   = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				empty_found = 1'b1;
				empty_idx   = IDX_W'(i);
			end
		end
	end

	// oldest-entry scan, strict compare keeps the lowest index on ties
	assign scan_age  = age_q[idx_q];
	assign scan_take = scan_age > best_age_q;
	assign scan_idx  = scan_take ? idx_q : best_idx_q;

	assign rd_idx    = (state_q == ST_FLUSH) ? idx_q : sel_q;
	assign store_off = slot_offset(base, guest_q[rd_idx], half_q[rd_idx]);

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			sel_q       <= '0;
			idx_q       <= '0;
			best_idx_q  <= '0;
			best_age_q  <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				away_q[i]  <= 1'b1;
				age_q[i]   <= '0;
				guest_q[i] <= '0;
				half_q[i]  <= 1'b0;
			end
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cmd_q <= q_data;
						unique case (q_data.op)
							OP_ACCESS: begin
								for (int i = 0; i < ENTRIES; i++) begin
									if (age_q[i] != AGE_MAX) begin
										age_q[i] <= age_q[i] + AGE_BITS'(1);
									end
								end
								if (hit_found) begin
									age_q[hit_idx] <= '0;
									sel_q <= hit_idx;
									if (away_q[hit_idx] && q_data.pre) begin
										away_q[hit_idx] <= 1'b0;
										state_q <= ST_LOAD;
									end else begin
										state_q <= ST_REPLY;
									end
								end else if (empty_found) begin
									valid_q[empty_idx] <= 1'b1;
									guest_q[empty_idx] <= q_data.guest;
									half_q[empty_idx]  <= q_data.half;
									age_q[empty_idx]   <= '0;
									away_q[empty_idx]  <= !q_data.pre;
									sel_q <= empty_idx;
									state_q <= q_data.pre ? ST_LOAD : ST_REPLY;
								end else begin
									idx_q      <= '0;
									best_idx_q <= '0;
									best_age_q <= '0;
									state_q    <= ST_SCAN;
								end
							end
							OP_FLUSH: begin
								idx_q   <= '0;
								state_q <= ST_FLUSH;
							end
							OP_DISCARD: begin
								for (int i = 0; i < ENTRIES; i++) begin
									valid_q[i] <= 1'b0;
									age_q[i]   <= '0;
								end
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_take) begin
						best_age_q <= scan_age;
					end
					best_idx_q <= scan_idx;
					idx_q      <= idx_q + IDX_W'(1);
					if (idx_q == IDX_LAST) begin
						sel_q   <= scan_idx;
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.kind          <= KIND_STORE;
						out_q.host_reg      <= host_of(sel_q);
						out_q.mem_offset    <= store_off;
						out_q.last          <= 1'b0;
						// reuse the victim for the new mapping
						valid_q[sel_q] <= 1'b1;
						guest_q[sel_q] <= cmd_q.guest;
						half_q[sel_q]  <= cmd_q.half;
						age_q[sel_q]   <= '0;
						away_q[sel_q]  <= !cmd_q.pre;
						state_q <= cmd_q.pre ? ST_LOAD : ST_REPLY;
					end
				end
				ST_LOAD: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_q.kind       <= KIND_LOAD;
						out_q.host_reg   <= host_of(sel_q);
						out_q.mem_offset <= cmd_q.load_off;
						out_q.last       <= 1'b0;
						state_q          <= ST_REPLY;
					end
				end
				ST_REPLY: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_q.kind       <= KIND_REPLY;
						out_q.host_reg   <= host_of(sel_q);
						out_q.mem_offset <= '0;
						out_q.last       <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_q.kind       <= KIND_REPLY;
						out_q.host_reg   <= '0;
						out_q.mem_offset <= '0;
						out_q.last       <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					// empty entries are skipped without waiting on the output
					if (!valid_q[idx_q] || out_free) begin
						if (valid_q[idx_q]) begin
							out_valid_q      <= 1'b1;
							out_q.kind       <= KIND_STORE;
							out_q.host_reg   <= host_of(idx_q);
							out_q.mem_offset <= store_off;
							out_q.last       <= 1'b0;
							valid_q[idx_q]   <= 1'b0;
							age_q[idx_q]     <= '0;
							away_q[idx_q]    <= 1'b1;
						end
						idx_q <= idx_q + IDX_W'(1);
						if (idx_q == IDX_LAST) begin
							state_q <= ST_DONE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/guest_fpr_register_cache.sv @@
`timescale 1ns / 1ps

// Guest float-register cache: maps guest paired-single register halves onto host
// registers D4..D31 (28 entries, fully associative, oldest-first replacement with
// 16-bit saturating ages). Each access beat yields an optional eviction store, an
// optional load and a final reply naming the host register; flush emits one store
// per valid entry and a done beat, discard empties all entries and emits a done beat.
// The front registers and classifies input beats and precomputes the load offset,
// a two-deep queue decouples it from the back engine, which handles one beat at a
// time. The back engine takes a beat from the queue when idle and emits each result
// beat from its own state, held by output stall; an eviction first scans the ages of
// all 28 entries for the victim; flush walks all 28 entries, one per cycle unless a
// store waits on the stall, then its done beat. The base offset register may be
// written only while the block is idle. No clearing pass after reset.

module guest_fpr_register_cache (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [gfrc_pkg::OFF_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  gfrc_pkg::in_t              in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output gfrc_pkg::out_t             out_data
);
	import gfrc_pkg::*;

	logic [OFF_W-1:0] base_q;
	logic             push_valid;
	logic             push_ready;
	cmd_t             push_data;
	logic             pop_valid;
	logic             pop_ready;
	cmd_t             pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	gfrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.base       (base_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	gfrc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	gfrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.base      (base_q),
		.q_valid   (pop_valid),
		.q_pop     (pop_ready),
		.q_data    (pop_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
